@@ rtl/bale_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bale_pkg
// Shared widths, operation codes and defaults for the bounded array list.
// ----------------------------------------------------------------------------
package bale_pkg;

    localparam int DATA_W       = 32;
    localparam int COUNT_W      = 8;
    localparam int FUNC_W       = 3;
    localparam int CAPACITY_DEF = 128;

    localparam logic [FUNC_W-1:0] OP_APPEND = 3'd0;
    localparam logic [FUNC_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [FUNC_W-1:0] OP_FIND   = 3'd2;
    localparam logic [FUNC_W-1:0] OP_GET    = 3'd3;
    localparam logic [FUNC_W-1:0] OP_CLEAR  = 3'd4;

endpackage

@@ rtl/bale_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bale_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bale_ram
    import bale_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_wa,
    input  logic [DATA_W-1:0] i_wd,
    input  logic              i_re,
    input  logic [AW-1:0]     i_ra,
    output logic [DATA_W-1:0] o_rd
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        if (i_re) begin
            r_rd <= r_mem[i_ra];
        end
    end

    assign o_rd = r_rd;

endmodule

@@ rtl/bounded_array_list_engine_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_array_list_engine_unit
// Bounded ordered list of signed 32-bit words with append, remove, find,
// get and clear requests.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: i_valid / o_stall with i_func, i_value, i_index. A
//   request is taken at a clock edge with i_valid high and o_stall low.
//   Result channel: o_valid / i_stall with o_success, o_read_value,
//   o_count, o_is_empty. One result per request, in request order.
//   One request is in work at a time; o_stall is high from the cycle after
//   acceptance until the result is placed in the output register.
//   Work between acceptance and the result, per request:
//     append, clear, unknown code, get with bad index: no further step
//     get: one read of the entry store
//     find: a scan of the stored entries, one stored entry read per cycle
//     remove: a scan, then a shift of later entries; each reads one entry
//       per cycle through the single read port of the entry store.
//   The output register parts the two sides: a new request is taken while a
//   result still waits; its own result waits in the engine until the
//   output register frees.
//   Reset (i_rst_n low, synchronous) empties the list and drops any result;
//   the entry store itself is not cleared, since only counted entries are
//   ever read.
// ----------------------------------------------------------------------------
module bounded_array_list_engine_unit
    import bale_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [FUNC_W-1:0]        i_func,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [COUNT_W-1:0]       i_index,
    // result channel
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_success,
    output logic signed [DATA_W-1:0] o_read_value,
    output logic [COUNT_W-1:0]       o_count,
    output logic                     o_is_empty
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [COUNT_W-1:0] CAP_C = COUNT_W'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GET,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } t_state;

    // control and result registers
    t_state             r_state,  n_state;
    logic [FUNC_W-1:0]  r_func,   n_func;
    logic [DATA_W-1:0]  r_value,  n_value;
    logic [COUNT_W-1:0] r_count,  n_count;
    logic               r_ok,     n_ok;
    logic [DATA_W-1:0]  r_rd,     n_rd;
    // next read position, and the position whose data is due from the store
    logic [COUNT_W-1:0] r_ptr,    n_ptr;
    logic               r_pend,   n_pend;
    logic [COUNT_W-1:0] r_pend_pos, n_pend_pos;
    // output register
    logic               r_out_valid, n_out_valid;
    logic               r_out_ok;
    logic [DATA_W-1:0]  r_out_rd;
    logic [COUNT_W-1:0] r_out_count;

    // entry store port
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_wa, mem_ra;
    logic [DATA_W-1:0] mem_wd, mem_rd;

    logic               accept;
    logic               load_out;
    logic               hit;
    logic [COUNT_W-1:0] shift_wa;

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && !o_stall;
    assign load_out = (r_state == S_RESP) && (!r_out_valid || !i_stall);
    assign hit      = r_pend && (mem_rd == r_value);
    // a shift writes each entry one place below where it was read
    assign shift_wa = r_pend_pos - COUNT_W'(1);

    always_comb begin
        n_state    = r_state;
        n_func     = r_func;
        n_value    = r_value;
        n_count    = r_count;
        n_ok       = r_ok;
        n_rd       = r_rd;
        n_ptr      = r_ptr;
        n_pend     = r_pend;
        n_pend_pos = r_pend_pos;
        mem_we     = 1'b0;
        mem_wa     = shift_wa[AW-1:0];
        mem_wd     = mem_rd;
        mem_re     = 1'b0;
        mem_ra     = r_ptr[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_func  = i_func;
                    n_value = i_value;
                    n_ok    = 1'b0;
                    n_rd    = '0;
                    n_ptr   = '0;
                    n_pend  = 1'b0;
                    n_state = S_RESP;
                    unique case (i_func)
                        OP_APPEND: begin
                            if (r_count < CAP_C) begin
                                mem_we  = 1'b1;
                                mem_wa  = r_count[AW-1:0];
                                mem_wd  = i_value;
                                n_count = r_count + COUNT_W'(1);
                                n_ok    = 1'b1;
                            end
                        end
                        OP_REMOVE, OP_FIND: begin
                            n_state = S_SCAN;
                        end
                        OP_GET: begin
                            if (i_index < r_count) begin
                                mem_re  = 1'b1;
                                mem_ra  = i_index[AW-1:0];
                                n_state = S_GET;
                            end else begin
                                n_rd = '1;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                            n_ok    = 1'b1;
                        end
                        default: begin
                            n_ok = 1'b0;
                        end
                    endcase
                end
            end
            S_GET: begin
                n_rd    = mem_rd;
                n_ok    = 1'b1;
                n_state = S_RESP;
            end
            S_SCAN: begin
                priority if (hit) begin
                    n_pend = 1'b0;
                    if (r_func == OP_REMOVE) begin
                        n_ptr   = r_pend_pos + COUNT_W'(1);
                        n_state = S_SHIFT;
                    end else begin
                        n_ok    = 1'b1;
                        n_state = S_RESP;
                    end
                end else if (r_ptr < r_count) begin
                    mem_re     = 1'b1;
                    n_pend     = 1'b1;
                    n_pend_pos = r_ptr;
                    n_ptr      = r_ptr + COUNT_W'(1);
                end else if (!r_pend) begin
                    n_ok    = 1'b0;
                    n_state = S_RESP;
                end else begin
                    n_pend = 1'b0;
                end
            end
            S_SHIFT: begin
                mem_we = r_pend;
                priority if (r_ptr < r_count) begin
                    mem_re     = 1'b1;
                    n_pend     = 1'b1;
                    n_pend_pos = r_ptr;
                    n_ptr      = r_ptr + COUNT_W'(1);
                end else if (!r_pend) begin
                    n_count = r_count - COUNT_W'(1);
                    n_ok    = 1'b1;
                    n_state = S_RESP;
                end else begin
                    n_pend = 1'b0;
                end
            end
            S_RESP: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_func     <= n_func;
        r_value    <= n_value;
        r_ok       <= n_ok;
        r_rd       <= n_rd;
        r_ptr      <= n_ptr;
        r_pend_pos <= n_pend_pos;
        if (load_out) begin
            r_out_ok    <= r_ok;
            r_out_rd    <= r_rd;
            r_out_count <= r_count;
        end
    end

    bale_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk (i_clk),
        .i_we  (mem_we),
        .i_wa  (mem_wa),
        .i_wd  (mem_wd),
        .i_re  (mem_re),
        .i_ra  (mem_ra),
        .o_rd  (mem_rd)
    );

    assign o_valid      = r_out_valid;
    assign o_success    = r_out_ok;
    assign o_read_value = r_out_rd;
    assign o_count      = r_out_count;
    assign o_is_empty   = (r_out_count == '0);

endmodule

@@ rtl/bale_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bale_chk
// Port-level checks for the bounded array list, bound to the top level.
// ----------------------------------------------------------------------------
module bale_chk
    import bale_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_stall,
    input logic                     o_valid,
    input logic                     i_stall,
    input logic                     o_success,
    input logic signed [DATA_W-1:0] o_read_value,
    input logic [COUNT_W-1:0]       o_count,
    input logic                     o_is_empty
);

    localparam logic [COUNT_W-1:0] CAP_C = COUNT_W'(CAPACITY);

    // one request in work: the engine stalls right after taking one
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request accepted while one is in work");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_empty == (o_count == '0)))
        else $error("empty flag disagrees with count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_count <= CAP_C))
        else $error("count beyond capacity");

    // a failed result reads back zero or the bad-index marker
    a_fail_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_success) |-> (o_read_value == '0 || o_read_value == '1))
        else $error("failed result carries a read value");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_count) && $stable(o_read_value)))
        else $error("stalled result changed");

endmodule

bind bounded_array_list_engine_unit bale_chk #(
    .CAPACITY (CAPACITY)
) u_bale_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_success    (o_success),
    .o_read_value (o_read_value),
    .o_count      (o_count),
    .o_is_empty   (o_is_empty)
);
